// File: hdl/pci_pkg.sv
package pci_pkg;

   // Field widths fixed by the interface.
   localparam int EventWidth  = 16;
   localparam int TimeWidth   = 32;
   localparam int SampleWidth = 16;
   localparam int SumWidth    = 29;
   localparam int CountWidth  = 13;
   localparam int MarginWidth = 16;
   localparam int CsrWidth    = 32;
   localparam int CsrIdxWidth = 3;

   // Largest count the counters can hold.
   localparam int CountLimit = 8191;

   // Default window capacity.
   localparam int MaxSamplesDefault = 4096;

   // Depth of the queue between front and back.
   localparam int QueueDepth = 2;

   // Width of the scaled pedestal product and of the divider.
   localparam int DivWidth = SumWidth + CountWidth + 1;

   // Saturation bounds of a charge.
   localparam logic signed [SumWidth-1:0] ChargeMax = {1'b0, {(SumWidth-1){1'b1}}};
   localparam logic signed [SumWidth-1:0] ChargeMin = {1'b1, {(SumWidth-1){1'b0}}};

   // Configuration register indexes.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PED_START    = 3'd0,
      CSR_PED_END      = 3'd1,
      CSR_SIGNAL_START = 3'd2,
      CSR_SIGNAL_END   = 3'd3,
      CSR_PULSE_START  = 3'd4,
      CSR_PULSE_END    = 3'd5,
      CSR_RISE_MARGIN  = 3'd6,
      CSR_MIN_START    = 3'd7
   } csr_index_type;

   // Input command codes.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   // Snapshot of a finished event, handed from front to back.
   typedef struct packed {
      logic [EventWidth-1:0]      event_id;
      logic signed [SumWidth-1:0] ped_sum_first;
      logic signed [SumWidth-1:0] ped_sum_second;
      logic signed [SumWidth-1:0] signal_sum;
      logic signed [SumWidth-1:0] pulse_sum;
      logic [CountWidth-1:0]      ped_count;
      logic [CountWidth-1:0]      signal_count;
      logic [CountWidth-1:0]      pulse_count;
      logic [TimeWidth-1:0]       rise_time;
      logic                       rise_seen;
   } event_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: hdl/pulse_charge_integrator_top.sv
// Pulse charge integrator. Samples arrive on the req_ ports and are accepted
// one per cycle while full is low; each sample is folded into at most one of its
// event's pedestal, signal or pulse window sums in the cycle it is accepted. A
// change of event id, or a flush command, hands the finished event to a
// two-entry queue; its result then appears on the rsp_ ports, the baseline
// charges coming out of a restoring divider that produces one quotient bit per
// cycle. Samples keep flowing while events are divided; full rises only when
// the queue holds two finished events, so events that arrive faster than they
// are divided stall the input. Configuration is written through csr_ while the
// block is idle, a rule on the user that the block itself does not enforce.
module pulse_charge_integrator_top #(
   parameter int MAX_SAMPLES = pci_pkg::MaxSamplesDefault
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write,
   input  logic [pci_pkg::CsrIdxWidth-1:0]         csr_index,
   input  logic [pci_pkg::CsrWidth-1:0]            csr_data,
   input  logic                                    push,
   output logic                                    full,
   input  logic                                    req_command,
   input  logic [pci_pkg::EventWidth-1:0]          req_event_id,
   input  logic [pci_pkg::TimeWidth-1:0]           req_sample_time,
   input  logic signed [pci_pkg::SampleWidth-1:0]  req_signal_sample,
   input  logic signed [pci_pkg::SampleWidth-1:0]  req_pulse_sample,
   output logic                                    empty,
   input  logic                                    pop,
   output logic [pci_pkg::EventWidth-1:0]          rsp_done_event,
   output logic signed [pci_pkg::SumWidth-1:0]     rsp_charge_signal,
   output logic signed [pci_pkg::SumWidth-1:0]     rsp_charge_pulse,
   output logic [pci_pkg::TimeWidth-1:0]           rsp_return_time,
   output logic                                    rsp_return_found,
   output logic                                    rsp_baseline_valid
);

   pci_pkg::queue_status_type status;
   pci_pkg::event_type        emit_data;
   pci_pkg::event_type        head;
   logic                      emit;
   logic                      take;
   logic                      accept;

   assign full   = status.full;
   assign accept = push && !status.full;

   pci_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .accept        (accept),
      .command       (req_command),
      .event_id      (req_event_id),
      .sample_time   (req_sample_time),
      .signal_sample (req_signal_sample),
      .pulse_sample  (req_pulse_sample),
      .emit          (emit),
      .emit_data     (emit_data)
   );

   pci_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (emit_data),
      .pop       (take),
      .pop_data  (head),
      .status    (status)
   );

   pci_back u_back (
      .clock          (clock),
      .reset          (reset),
      .status         (status),
      .entry          (head),
      .take           (take),
      .pop            (pop),
      .empty          (empty),
      .done_event     (rsp_done_event),
      .charge_signal  (rsp_charge_signal),
      .charge_pulse   (rsp_charge_pulse),
      .return_time    (rsp_return_time),
      .return_found   (rsp_return_found),
      .baseline_valid (rsp_baseline_valid)
   );

endmodule

// File: hdl/pci_fifo.sv
module pci_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pci_pkg::event_type      push_data,
   input  logic                    pop,
   output pci_pkg::event_type      pop_data,
   output pci_pkg::queue_status_type status
);

   localparam int PtrWidth = $clog2(pci_pkg::QueueDepth);

   pci_pkg::event_type          mem_ff [pci_pkg::QueueDepth];
   logic [PtrWidth-1:0]         wr_ptr_ff;
   logic [PtrWidth-1:0]         rd_ptr_ff;
   logic [PtrWidth:0]           count_ff;
   logic                        do_push;
   logic                        do_pop;

   assign status.full  = (count_ff == (PtrWidth+1)'(pci_pkg::QueueDepth));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   // Storage is written only; pointers and fill count are control state.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(pci_pkg::QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(pci_pkg::QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PtrWidth+1)'(do_push) - (PtrWidth+1)'(do_pop);
      end
   end

endmodule

// File: hdl/pci_front.sv
module pci_front #(
   parameter int MAX_SAMPLES = pci_pkg::MaxSamplesDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [pci_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [pci_pkg::CsrWidth-1:0]         csr_data,
   input  logic                                 accept,
   input  logic                                 command,
   input  logic [pci_pkg::EventWidth-1:0]       event_id,
   input  logic [pci_pkg::TimeWidth-1:0]        sample_time,
   input  logic signed [pci_pkg::SampleWidth-1:0] signal_sample,
   input  logic signed [pci_pkg::SampleWidth-1:0] pulse_sample,
   output logic                                 emit,
   output pci_pkg::event_type                   emit_data
);

   localparam int CountCap = (MAX_SAMPLES < pci_pkg::CountLimit) ? MAX_SAMPLES
                                                                 : pci_pkg::CountLimit;
   localparam logic [pci_pkg::CountWidth-1:0] CapValue = pci_pkg::CountWidth'(CountCap);

   // Configuration registers.
   logic [pci_pkg::TimeWidth-1:0]   ped_start_ff, ped_end_ff;
   logic [pci_pkg::TimeWidth-1:0]   sig_start_ff, sig_end_ff;
   logic [pci_pkg::TimeWidth-1:0]   pls_start_ff, pls_end_ff;
   logic [pci_pkg::MarginWidth-1:0] margin_ff;
   logic signed [pci_pkg::SampleWidth-1:0] min_start_ff;

   // Event state.
   pci_pkg::event_type                     ev_ff, ev_in, base;
   logic                                   open_ff, open_in;
   logic signed [pci_pkg::SampleWidth-1:0] min_ff, min_in, base_min;
   logic                                   opening;
   logic                                   in_ped, in_sig, in_pls;
   logic signed [pci_pkg::SampleWidth+1:0] rise_limit;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ped_start_ff <= '0;
         ped_end_ff   <= '0;
         sig_start_ff <= '0;
         sig_end_ff   <= '0;
         pls_start_ff <= '0;
         pls_end_ff   <= '0;
         margin_ff    <= '0;
         min_start_ff <= 16'sh7FFF;
      end else if (csr_write) begin
         case (pci_pkg::csr_index_type'(csr_index))
            pci_pkg::CSR_PED_START:    ped_start_ff <= csr_data;
            pci_pkg::CSR_PED_END:      ped_end_ff   <= csr_data;
            pci_pkg::CSR_SIGNAL_START: sig_start_ff <= csr_data;
            pci_pkg::CSR_SIGNAL_END:   sig_end_ff   <= csr_data;
            pci_pkg::CSR_PULSE_START:  pls_start_ff <= csr_data;
            pci_pkg::CSR_PULSE_END:    pls_end_ff   <= csr_data;
            pci_pkg::CSR_RISE_MARGIN:  margin_ff    <= csr_data[pci_pkg::MarginWidth-1:0];
            pci_pkg::CSR_MIN_START:    min_start_ff <= $signed(csr_data[pci_pkg::SampleWidth-1:0]);
            default: ;
         endcase
      end
   end

   // A new event opens on the first sample after reset or a flush, or on a change of id.
   assign opening = !open_ff || (event_id != ev_ff.event_id);
   assign emit    = accept && open_ff && ((command == pci_pkg::CMD_FLUSH) ||
                                          (event_id != ev_ff.event_id));
   assign emit_data = ev_ff;

   assign in_ped = (ped_start_ff < sample_time) && (sample_time < ped_end_ff);
   assign in_sig = (sig_start_ff < sample_time) && (sample_time < sig_end_ff);
   assign in_pls = (pls_start_ff < sample_time) && (sample_time < pls_end_ff);

   // Accumulate one sample onto the open or the freshly cleared event.
   always_comb begin
      base     = ev_ff;
      base_min = min_ff;
      if (opening) begin
         base          = '0;
         base.event_id = event_id;
         base_min      = min_start_ff;
      end
      ev_in    = base;
      min_in   = (pulse_sample < base_min) ? pulse_sample : base_min;
      rise_limit = 18'(min_in) + $signed({2'b00, margin_ff});
      if (!base.rise_seen && (18'(pulse_sample) > rise_limit)) begin
         ev_in.rise_time = sample_time;
         ev_in.rise_seen = 1'b1;
      end
      if (in_ped) begin
         if (base.ped_count < CapValue) begin
            ev_in.ped_sum_first  = base.ped_sum_first  + pci_pkg::SumWidth'(signal_sample);
            ev_in.ped_sum_second = base.ped_sum_second + pci_pkg::SumWidth'(pulse_sample);
            ev_in.ped_count      = base.ped_count + 1'b1;
         end
      end else if (in_sig) begin
         if (base.signal_count < CapValue) begin
            ev_in.signal_sum   = base.signal_sum + pci_pkg::SumWidth'(signal_sample);
            ev_in.signal_count = base.signal_count + 1'b1;
         end
      end else if (in_pls) begin
         if (base.pulse_count < CapValue) begin
            ev_in.pulse_sum   = base.pulse_sum + pci_pkg::SumWidth'(pulse_sample);
            ev_in.pulse_count = base.pulse_count + 1'b1;
         end
      end
      open_in = (command == pci_pkg::CMD_SAMPLE) ? 1'b1 : 1'b0;
   end

   // The open flag updates on every accepted item, the event registers on every accepted sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         ev_ff   <= '0;
         min_ff  <= 16'sh7FFF;
      end else if (accept) begin
         open_ff <= open_in;
         if (command == pci_pkg::CMD_SAMPLE) begin
            ev_ff  <= ev_in;
            min_ff <= min_in;
         end
      end
   end

endmodule

// File: hdl/pci_back.sv
module pci_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pci_pkg::queue_status_type             status,
   input  pci_pkg::event_type                    entry,
   output logic                                  take,
   input  logic                                  pop,
   output logic                                  empty,
   output logic [pci_pkg::EventWidth-1:0]        done_event,
   output logic signed [pci_pkg::SumWidth-1:0]   charge_signal,
   output logic signed [pci_pkg::SumWidth-1:0]   charge_pulse,
   output logic [pci_pkg::TimeWidth-1:0]         return_time,
   output logic                                  return_found,
   output logic                                  baseline_valid
);

   localparam int DW = pci_pkg::DivWidth;
   localparam int CW = pci_pkg::CountWidth;
   localparam int SW = pci_pkg::SumWidth;
   localparam int StepWidth = $clog2(DW + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type                 state_ff;
   pci_pkg::event_type        job_ff;
   logic signed [DW-1:0]      prod_ff [2];
   logic [DW-1:0]             quo_ff  [2];
   logic [CW:0]               rem_ff  [2];
   logic                      neg_ff  [2];
   logic [StepWidth-1:0]      step_ff;
   logic                      out_valid_ff;
   logic                      out_free;
   logic [CW:0]               trial   [2];
   logic signed [DW+1:0]      result  [2];
   logic signed [SW-1:0]      charge  [2];
   logic signed [SW-1:0]      sums    [2];

   assign take     = (state_ff == ST_IDLE) && !status.empty;
   assign empty    = !out_valid_ff;
   assign out_free = !out_valid_ff || pop;
   assign sums[0]  = job_ff.signal_sum;
   assign sums[1]  = job_ff.pulse_sum;

   // Signed quotient minus the window sum, saturated to the charge range.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         trial[i]  = {rem_ff[i][CW-1:0], quo_ff[i][DW-1]};
         result[i] = (neg_ff[i] ? -$signed({2'b00, quo_ff[i]}) : $signed({2'b00, quo_ff[i]}))
                     - (DW+2)'(sums[i]);
         if (result[i] > (DW+2)'(pci_pkg::ChargeMax)) begin
            charge[i] = pci_pkg::ChargeMax;
         end else if (result[i] < (DW+2)'(pci_pkg::ChargeMin)) begin
            charge[i] = pci_pkg::ChargeMin;
         end else begin
            charge[i] = result[i][SW-1:0];
         end
      end
   end

   // Sequencer: multiply, take magnitude, divide one bit a cycle, deliver; no pedestal skips to deliver.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (pop && out_valid_ff && (state_ff != ST_FIN)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!status.empty) begin
                  job_ff   <= entry;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff[0] <= $signed(DW'(job_ff.ped_sum_first)) *
                             $signed({{(DW-CW){1'b0}}, job_ff.signal_count});
               prod_ff[1] <= $signed(DW'(job_ff.ped_sum_second)) *
                             $signed({{(DW-CW){1'b0}}, job_ff.pulse_count});
               state_ff   <= (job_ff.ped_count == '0) ? ST_FIN : ST_PREP;
            end
            ST_PREP: begin
               for (int i = 0; i < 2; i++) begin
                  neg_ff[i] <= prod_ff[i][DW-1];
                  quo_ff[i] <= (prod_ff[i][DW-1] ? DW'(-prod_ff[i]) : DW'(prod_ff[i]))
                               + DW'(job_ff.ped_count >> 1);
                  rem_ff[i] <= '0;
               end
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               for (int i = 0; i < 2; i++) begin
                  if (trial[i] >= {1'b0, job_ff.ped_count}) begin
                     rem_ff[i] <= trial[i] - {1'b0, job_ff.ped_count};
                     quo_ff[i] <= {quo_ff[i][DW-2:0], 1'b1};
                  end else begin
                     rem_ff[i] <= trial[i];
                     quo_ff[i] <= {quo_ff[i][DW-2:0], 1'b0};
                  end
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == StepWidth'(DW - 1)) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  out_valid_ff   <= 1'b1;
                  done_event     <= job_ff.event_id;
                  baseline_valid <= (job_ff.ped_count != '0);
                  charge_signal  <= (job_ff.ped_count != '0) ? charge[0] : '0;
                  charge_pulse   <= (job_ff.ped_count != '0) ? charge[1] : '0;
                  return_found   <= job_ff.rise_seen;
                  return_time    <= job_ff.rise_seen ? job_ff.rise_time : '0;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // A waiting result holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |=> (out_valid_ff && $stable(charge_signal) && $stable(done_event)))
      else $error("waiting result changed before it was taken");

   // An event without pedestal reports zero charge.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !baseline_valid) |-> (charge_signal == '0 && charge_pulse == '0))
      else $error("nonzero charge without a baseline");

   // The divider never runs past its last step.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff < StepWidth'(DW)))
      else $error("divider step out of range");

   // A queue entry is taken only when the sequencer is free.
   assert property (@(posedge clock) disable iff (reset)
      take |=> (state_ff == ST_MUL))
      else $error("queue entry taken while busy");

endmodule

// File: dv/pulse_charge_integrator_top_tb.sv
`timescale 1ns / 100ps

module pulse_charge_integrator_top_tb;

   // Result record of one finished event.
   typedef struct {
      logic [pci_pkg::EventWidth-1:0]      done_event;
      logic signed [pci_pkg::SumWidth-1:0] charge_signal;
      logic signed [pci_pkg::SumWidth-1:0] charge_pulse;
      logic [pci_pkg::TimeWidth-1:0]       return_time;
      logic                                return_found;
      logic                                baseline_valid;
   } charge_result_type;

   localparam int WindowCap  = (pci_pkg::MaxSamplesDefault < pci_pkg::CountLimit) ?
                               pci_pkg::MaxSamplesDefault : pci_pkg::CountLimit;
   localparam int IdleLimit  = 20000;
   localparam int DrainWait  = 80;

   logic                                   clock;
   logic                                   reset;
   logic                                   csr_write;
   logic [pci_pkg::CsrIdxWidth-1:0]        csr_index;
   logic [pci_pkg::CsrWidth-1:0]           csr_data;
   logic                                   push;
   logic                                   full;
   logic                                   req_command;
   logic [pci_pkg::EventWidth-1:0]         req_event_id;
   logic [pci_pkg::TimeWidth-1:0]          req_sample_time;
   logic signed [pci_pkg::SampleWidth-1:0] req_signal_sample;
   logic signed [pci_pkg::SampleWidth-1:0] req_pulse_sample;
   logic                                   empty;
   logic                                   pop;
   logic [pci_pkg::EventWidth-1:0]         rsp_done_event;
   logic signed [pci_pkg::SumWidth-1:0]    rsp_charge_signal;
   logic signed [pci_pkg::SumWidth-1:0]    rsp_charge_pulse;
   logic [pci_pkg::TimeWidth-1:0]          rsp_return_time;
   logic                                   rsp_return_found;
   logic                                   rsp_baseline_valid;

   pulse_charge_integrator_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .push               (push),
      .full               (full),
      .req_command        (req_command),
      .req_event_id       (req_event_id),
      .req_sample_time    (req_sample_time),
      .req_signal_sample  (req_signal_sample),
      .req_pulse_sample   (req_pulse_sample),
      .empty              (empty),
      .pop                (pop),
      .rsp_done_event     (rsp_done_event),
      .rsp_charge_signal  (rsp_charge_signal),
      .rsp_charge_pulse   (rsp_charge_pulse),
      .rsp_return_time    (rsp_return_time),
      .rsp_return_found   (rsp_return_found),
      .rsp_baseline_valid (rsp_baseline_valid)
   );

   // Predictor copy of the configuration and the event state.
   logic [pci_pkg::CsrWidth-1:0] window_reg [8];
   logic [pci_pkg::EventWidth-1:0] open_event;
   logic event_is_open;
   int ped_first_sum, ped_second_sum, signal_win_sum, pulse_win_sum;
   int ped_samples, signal_samples, pulse_samples;
   int lowest_pulse;
   logic [pci_pkg::TimeWidth-1:0] first_rise_time;
   logic first_rise_seen;

   charge_result_type pending_charges[$];
   int error_count;
   int idle_cycles;
   int pop_hold;
   logic sender_quiet;
   logic receiver_quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, a few long ones.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 70);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   // Starts a new event in the predictor.
   function automatic void open_fresh_event();
      ped_first_sum   = 0;
      ped_second_sum  = 0;
      signal_win_sum  = 0;
      pulse_win_sum   = 0;
      ped_samples     = 0;
      signal_samples  = 0;
      pulse_samples   = 0;
      lowest_pulse    = int'($signed(window_reg[pci_pkg::CSR_MIN_START][15:0]));
      first_rise_time = '0;
      first_rise_seen = 1'b0;
   endfunction

   // Baseline-scaled charge, rounded to nearest with ties away from zero.
   function automatic logic signed [pci_pkg::SumWidth-1:0] baseline_charge(input int ped_sum,
         input int win_count, input int win_sum);
      longint num, mag, quot, diff;
      num  = longint'(ped_sum) * longint'(win_count);
      mag  = (num < 0) ? -num : num;
      quot = (mag + ped_samples / 2) / ped_samples;
      if (num < 0) quot = -quot;
      diff = quot - longint'(win_sum);
      if (diff > longint'(pci_pkg::ChargeMax)) diff = longint'(pci_pkg::ChargeMax);
      if (diff < longint'(pci_pkg::ChargeMin)) diff = longint'(pci_pkg::ChargeMin);
      return diff[pci_pkg::SumWidth-1:0];
   endfunction

   function automatic void queue_event_charges();
      charge_result_type res;
      res.done_event     = open_event;
      res.baseline_valid = (ped_samples != 0);
      res.charge_signal  = res.baseline_valid ?
            baseline_charge(ped_first_sum, signal_samples, signal_win_sum) : '0;
      res.charge_pulse   = res.baseline_valid ?
            baseline_charge(ped_second_sum, pulse_samples, pulse_win_sum) : '0;
      res.return_found   = first_rise_seen;
      res.return_time    = first_rise_seen ? first_rise_time : '0;
      pending_charges.push_back(res);
   endfunction

   function automatic logic in_window(input logic [pci_pkg::TimeWidth-1:0] t,
         input int lo_idx);
      return (window_reg[lo_idx] < t) && (t < window_reg[lo_idx+1]);
   endfunction

   // Folds one accepted item into the predictor.
   function automatic void integrate_item(input logic cmd,
         input logic [pci_pkg::EventWidth-1:0] ev,
         input logic [pci_pkg::TimeWidth-1:0] t, input int s1, input int s2);
      if (cmd == pci_pkg::CMD_FLUSH) begin
         if (event_is_open) begin
            queue_event_charges();
            event_is_open = 1'b0;
            open_fresh_event();
         end
         return;
      end
      if (!event_is_open || ev != open_event) begin
         if (event_is_open) queue_event_charges();
         open_fresh_event();
         open_event    = ev;
         event_is_open = 1'b1;
      end
      if (s2 < lowest_pulse) lowest_pulse = s2;
      if (!first_rise_seen &&
            s2 > lowest_pulse + int'(window_reg[pci_pkg::CSR_RISE_MARGIN][15:0])) begin
         first_rise_time = t;
         first_rise_seen = 1'b1;
      end
      if (in_window(t, pci_pkg::CSR_PED_START)) begin
         if (ped_samples < WindowCap) begin
            ped_first_sum  += s1;
            ped_second_sum += s2;
            ped_samples++;
         end
      end else if (in_window(t, pci_pkg::CSR_SIGNAL_START)) begin
         if (signal_samples < WindowCap) begin
            signal_win_sum += s1;
            signal_samples++;
         end
      end else if (in_window(t, pci_pkg::CSR_PULSE_START)) begin
         if (pulse_samples < WindowCap) begin
            pulse_win_sum += s2;
            pulse_samples++;
         end
      end
   endfunction

   // Sends one item and waits for it to be taken.
   task automatic send_item(input logic cmd, input logic [pci_pkg::EventWidth-1:0] ev,
         input logic [pci_pkg::TimeWidth-1:0] t, input logic [15:0] s1,
         input logic [15:0] s2);
      int gap;
      push              <= 1'b1;
      req_command       <= cmd;
      req_event_id      <= ev;
      req_sample_time   <= t;
      req_signal_sample <= s1;
      req_pulse_sample  <= s2;
      do @(posedge clock); while (full);
      integrate_item(cmd, ev, t, int'($signed(s1)), int'($signed(s2)));
      gap = sender_quiet ? 0 : gap_length();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_sample(input logic [pci_pkg::EventWidth-1:0] ev,
         input logic [pci_pkg::TimeWidth-1:0] t,
         input logic [15:0] s1, input logic [15:0] s2);
      send_item(pci_pkg::CMD_SAMPLE, ev, t, s1, s2);
   endtask

   task automatic send_flush();
      send_item(pci_pkg::CMD_FLUSH, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
   endtask

   // Lets every expected result out and the back stage settle.
   task automatic wait_idle();
      push <= 1'b0;
      while (pending_charges.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_reg(input pci_pkg::csr_index_type idx,
         input logic [pci_pkg::CsrWidth-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == pci_pkg::CSR_RISE_MARGIN || idx == pci_pkg::CSR_MIN_START)
         value = {16'h0, value[15:0]};
      window_reg[idx] = value;
   endtask

   task automatic set_windows(input logic [31:0] ped_lo, input logic [31:0] ped_hi,
         input logic [31:0] sig_lo, input logic [31:0] sig_hi,
         input logic [31:0] pul_lo, input logic [31:0] pul_hi,
         input logic [15:0] margin, input logic [15:0] min_start);
      write_reg(pci_pkg::CSR_PED_START, ped_lo);
      write_reg(pci_pkg::CSR_PED_END, ped_hi);
      write_reg(pci_pkg::CSR_SIGNAL_START, sig_lo);
      write_reg(pci_pkg::CSR_SIGNAL_END, sig_hi);
      write_reg(pci_pkg::CSR_PULSE_START, pul_lo);
      write_reg(pci_pkg::CSR_PULSE_END, pul_hi);
      write_reg(pci_pkg::CSR_RISE_MARGIN, {16'h0, margin});
      write_reg(pci_pkg::CSR_MIN_START, {16'h0, min_start});
   endtask

   // Window priority, id changes, flushes and an empty pedestal.
   task automatic test_window_sums();
      set_windows(0, 100, 50, 200, 150, 300, 5, 16'h7fff);
      send_sample(16'h0001, 10, 16'h7fff, 16'h8000);
      send_sample(16'h0001, 60, 16'h8000, 16'h7fff);
      send_sample(16'h0001, 99, 16'h0003, 16'h0002);
      send_sample(16'h0001, 120, 16'h1234, 16'hff00);
      send_sample(16'h0001, 160, 16'h8000, 16'h0100);
      send_sample(16'h0001, 250, 16'h0005, 16'h7fff);
      send_sample(16'h0001, 300, 16'h7777, 16'h7777);
      // New id closes the first event; this one has no pedestal samples.
      send_sample(16'hffff, 120, 16'h0010, 16'h0000);
      send_sample(16'hffff, 200, 16'h0020, 16'h0001);
      send_flush();
      // Flush with nothing open is ignored.
      send_flush();
      // Same id again after a flush opens a new event silently.
      send_sample(16'hffff, 5, 16'h0001, 16'h0001);
      send_sample(16'hffff, 7, 16'h0002, 16'h0002);
      send_sample(16'hffff, 170, 16'h0003, 16'h0003);
      send_flush();
      wait_idle();
   endtask

   // Extreme register settings and timestamps.
   task automatic test_extremes();
      set_windows(0, 32'hffffffff, 32'hfffffffe, 32'hffffffff, 32'hffffffff, 32'hffffffff,
            16'hffff, 16'h8000);
      send_sample(16'h0000, 32'h0, 16'h8000, 16'h8000);
      send_sample(16'h0000, 32'hffffffff, 16'h7fff, 16'h7fff);
      send_sample(16'h0000, 32'h7fffffff, 16'h5555, 16'haaaa);
      send_flush();
      wait_idle();
      set_windows(32'hffffffff, 0, 0, 32'hffffffff, 0, 0, 16'h0000, 16'h7fff);
      send_sample(16'h8000, 32'h80000000, 16'h0001, 16'h0000);
      send_sample(16'h8000, 32'h00000001, 16'hfffe, 16'h0001);
      send_flush();
      wait_idle();
   endtask

   function automatic logic [pci_pkg::TimeWidth-1:0] pick_time();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return $urandom_range(0, 420);
      if (roll < 95) return $urandom;
      return roll[0] ? 32'hffffffff : 32'h0;
   endfunction

   // Several register settings, each with a stream of random events.
   task automatic test_random_events();
      int budget;
      int len;
      logic [pci_pkg::EventWidth-1:0] ev;
      for (int phase = 0; phase < 6; phase++) begin
         logic [31:0] p0, s0, u0;
         p0 = $urandom_range(0, 100);
         s0 = $urandom_range(0, 200);
         u0 = $urandom_range(0, 250);
         set_windows(p0, p0 + $urandom_range(0, 150), s0, s0 + $urandom_range(0, 200),
               u0, u0 + $urandom_range(0, 200), 16'($urandom_range(0, 3000)),
               (phase == 0) ? 16'h8000 : 16'($urandom));
         receiver_quiet = (phase == 2);
         sender_quiet   = (phase == 3);
         budget = 320;
         ev = 16'($urandom);
         while (budget > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 25);
            for (int i = 0; i < len && budget > 0; i++) begin
               send_sample(ev, pick_time(), 16'($urandom), 16'($urandom));
               budget--;
            end
            case ($urandom_range(0, 9))
               0: send_flush();
               1: ev = ev + 1;
               default: ev = 16'($urandom);
            endcase
         end
         send_flush();
         wait_idle();
      end
      receiver_quiet = 1'b0;
      sender_quiet   = 1'b0;
   endtask

   // Result checker.
   always @(posedge clock) begin
      charge_result_type want;
      if (!reset && pop && !empty) begin
         if (pending_charges.size() == 0) begin
            report_mismatch($sformatf("unexpected result for event %0h", rsp_done_event));
         end else begin
            want = pending_charges.pop_front();
            if (rsp_done_event !== want.done_event)
               report_mismatch($sformatf("done_event %0h, want %0h",
                     rsp_done_event, want.done_event));
            if (rsp_charge_signal !== want.charge_signal)
               report_mismatch($sformatf("event %0h charge_signal %0d, want %0d",
                     want.done_event, rsp_charge_signal, want.charge_signal));
            if (rsp_charge_pulse !== want.charge_pulse)
               report_mismatch($sformatf("event %0h charge_pulse %0d, want %0d",
                     want.done_event, rsp_charge_pulse, want.charge_pulse));
            if (rsp_return_time !== want.return_time)
               report_mismatch($sformatf("event %0h return_time %0h, want %0h",
                     want.done_event, rsp_return_time, want.return_time));
            if (rsp_return_found !== want.return_found)
               report_mismatch($sformatf("event %0h return_found %0b, want %0b",
                     want.done_event, rsp_return_found, want.return_found));
            if (rsp_baseline_valid !== want.baseline_valid)
               report_mismatch($sformatf("event %0h baseline_valid %0b, want %0b",
                     want.done_event, rsp_baseline_valid, want.baseline_valid));
         end
      end
   end

   // Receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         pop      <= 1'b0;
         pop_hold <= 0;
      end else if (receiver_quiet) begin
         pop <= 1'b1;
      end else if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
         pop_hold <= gap_length();
      end
   end

   // Watchdog on cycles without any item moving.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("pulse_charge_integrator_top test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      push = 1'b0;
      req_command = pci_pkg::CMD_SAMPLE;
      req_event_id = '0;
      req_sample_time = '0;
      req_signal_sample = '0;
      req_pulse_sample = '0;
      error_count = 0;
      sender_quiet = 1'b0;
      receiver_quiet = 1'b0;
      foreach (window_reg[i]) window_reg[i] = '0;
      window_reg[pci_pkg::CSR_MIN_START] = 32'h7fff;
      event_is_open = 1'b0;
      open_event = '0;
      open_fresh_event();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_window_sums();
      test_extremes();
      test_random_events();

      wait_idle();
      if (error_count == 0 && pending_charges.size() == 0) begin
         $display("pulse_charge_integrator_top test passed");
      end else begin
         $display("pulse_charge_integrator_top test failed");
      end
      $finish;
   end

endmodule

// File: pulse_charge_integrator_top.f
hdl/pci_pkg.sv
hdl/pci_fifo.sv
hdl/pci_front.sv
hdl/pci_back.sv
hdl/pulse_charge_integrator_top.sv
dv/pulse_charge_integrator_top_tb.sv
